// ===== rtl/button_gesture_dispatcher_macros.svh =====
// ============================================================================
// Assertion macros for the button gesture dispatcher
// Concurrent assertion helpers that compile away when SYNTHESIS is defined.
// ============================================================================
`ifndef BUTTON_GESTURE_DISPATCHER_MACROS_SVH
`define BUTTON_GESTURE_DISPATCHER_MACROS_SVH

`ifndef SYNTHESIS

// Overlapping implication, checked at every rising clock edge out of reset.
`define BGD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("button gesture dispatcher assertion failed");

// Implication into the next cycle.
`define BGD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("button gesture dispatcher assertion failed");

`else

`define BGD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BGD_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/bgd_pkg.sv =====
// ============================================================================
// Button gesture dispatcher package
// Types, constants and range tables shared by the dispatcher.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package bgd_pkg;

  localparam int BUTTON_COUNT = 128;

  localparam logic [7:0] STATUS_MASK = 8'hf0;
  localparam logic [7:0] STATUS_NOTE = 8'h90;
  localparam logic [6:0] VEL_PRESS   = 7'h40;
  localparam logic [6:0] HOLD_LO     = 7'h18;
  localparam logic [6:0] HOLD_HI     = 7'h1f;

  localparam logic [15:0] DCLICK_RESET = 16'd250;
  localparam logic [15:0] HOLD_RESET   = 16'd333;

  // Configuration register indexes.
  localparam logic [1:0] CFG_DCLICK = 2'd0;
  localparam logic [1:0] CFG_HOLD   = 2'd1;

  // Handler table codes.
  localparam logic [1:0] TAB_PRESS = 2'd0;
  localparam logic [1:0] TAB_PR    = 2'd1;
  localparam logic [1:0] TAB_HOLD  = 2'd2;

  typedef struct packed {
    logic [6:0] lo;
    logic [6:0] hi;
    logic       has_single;
    logic       has_double;
  } range_t;

  typedef struct packed {
    logic       hit;
    logic [4:0] entry;
    logic       has_single;
    logic       has_double;
  } match_t;

  typedef struct packed {
    logic [6:0] button;
    logic [1:0] handler_table;
    logic [4:0] handler_entry;
    logic       double_variant;
    logic       is_press;
    logic [6:0] velocity_out;
    logic [3:0] hold_index;
  } result_t;

  localparam int PRESS_ENTRIES = 17;
  localparam int PR_ENTRIES    = 16;

  // Press-only table. No entry offers both a single and a double handler.
  localparam range_t PRESS_TAB [PRESS_ENTRIES] = '{
    '{7'h08, 7'h0f, 1'b0, 1'b1}, '{7'h18, 7'h1f, 1'b0, 1'b1},
    '{7'h35, 7'h35, 1'b1, 1'b0}, '{7'h36, 7'h3d, 1'b1, 1'b0},
    '{7'h3e, 7'h45, 1'b1, 1'b0}, '{7'h4a, 7'h4e, 1'b1, 1'b0},
    '{7'h50, 7'h50, 1'b1, 1'b0}, '{7'h51, 7'h51, 1'b1, 1'b0},
    '{7'h52, 7'h52, 1'b1, 1'b0}, '{7'h56, 7'h56, 1'b1, 1'b0},
    '{7'h57, 7'h57, 1'b1, 1'b0}, '{7'h59, 7'h59, 1'b1, 1'b0},
    '{7'h5a, 7'h5a, 1'b1, 1'b0}, '{7'h5b, 7'h5f, 1'b0, 1'b1},
    '{7'h64, 7'h64, 1'b1, 1'b0}, '{7'h65, 7'h65, 1'b1, 1'b0},
    '{7'h71, 7'h71, 1'b1, 1'b0}
  };

  // Press/release table.
  localparam range_t PR_TAB [PR_ENTRIES] = '{
    '{7'h00, 7'h07, 1'b1, 1'b1}, '{7'h08, 7'h0f, 1'b1, 1'b0},
    '{7'h10, 7'h17, 1'b1, 1'b0}, '{7'h18, 7'h1f, 1'b1, 1'b0},
    '{7'h20, 7'h27, 1'b1, 1'b0}, '{7'h28, 7'h2d, 1'b1, 1'b0},
    '{7'h2e, 7'h31, 1'b1, 1'b0}, '{7'h32, 7'h32, 1'b1, 1'b0},
    '{7'h33, 7'h33, 1'b1, 1'b0}, '{7'h34, 7'h34, 1'b1, 1'b1},
    '{7'h46, 7'h49, 1'b1, 1'b0}, '{7'h54, 7'h54, 1'b1, 1'b0},
    '{7'h55, 7'h55, 1'b1, 1'b0}, '{7'h5b, 7'h5f, 1'b1, 1'b0},
    '{7'h60, 7'h63, 1'b1, 1'b0}, '{7'h68, 7'h70, 1'b1, 1'b0}
  };

  // The ranges of each table are disjoint, so at most one entry matches.
  function automatic match_t find_press(input logic [6:0] b);
    match_t m;
    m = '0;
    for (int i = 0; i < PRESS_ENTRIES; i++) begin
      if (PRESS_TAB[i].lo <= b && b <= PRESS_TAB[i].hi) begin
        m.hit        = 1'b1;
        m.entry      = 5'(i);
        m.has_single = PRESS_TAB[i].has_single;
        m.has_double = PRESS_TAB[i].has_double;
      end
    end
    return m;
  endfunction

  function automatic match_t find_pr(input logic [6:0] b);
    match_t m;
    m = '0;
    for (int i = 0; i < PR_ENTRIES; i++) begin
      if (PR_TAB[i].lo <= b && b <= PR_TAB[i].hi) begin
        m.hit        = 1'b1;
        m.entry      = 5'(i);
        m.has_single = PR_TAB[i].has_single;
        m.has_double = PR_TAB[i].has_double;
      end
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/button_gesture_dispatcher.sv =====
// ============================================================================
// Button gesture dispatcher
// Click, double click and long press detection for 128 note-coded buttons.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

`include "button_gesture_dispatcher_macros.svh"

// The block takes one word at a time and is not ready while it works on it.
// The last result word of an input may still wait in the output register
// when the next input word is taken. A note event is accepted, then looked up and
// updated, then gives its result words (none to two) one at a time, each waiting
// for a free output register. A note event with a status other than a note-on
// status is dropped on acceptance and gives nothing. A frame tick is accepted,
// then runs eight scan steps over buttons 0x18 to 0x1f and one flush step. The
// sequence follows from the single shared subtract-and-compare unit, which handles
// one time difference per cycle, and from output back-pressure, which holds the
// sequencer whenever a result word finds the output register still full.
module button_gesture_dispatcher
  import bgd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_tvalid,
  output      logic        in_tready,
  // status_byte[7:0], button_code[14:8], velocity[21:15], time_ms[53:22]
  input  wire logic [55:0] in_tdata,
  // operation[0]
  input  wire logic        in_tuser,

  output      logic        out_tvalid,
  input  wire logic        out_tready,
  // button[6:0], handler_entry[11:7], double_variant[12], is_press[13],
  // velocity_out[20:14], hold_index[24:21]
  output      logic [31:0] out_tdata,
  // handler_table[1:0]
  output      logic [1:0]  out_tuser,
  output      logic        out_tlast,

  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NOTE,
    ST_EMIT,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  state_t state_r, state_nxt;

  logic [15:0] dclick_r, hold_r;

  logic [6:0]  btn_r, btn_nxt;
  logic [6:0]  vel_r, vel_nxt;
  logic [31:0] now_r, now_nxt;

  logic [BUTTON_COUNT-1:0] pressed_r, pressed_nxt;
  logic [BUTTON_COUNT-1:0] double_r, double_nxt;
  logic [BUTTON_COUNT-1:0] hold_used_r, hold_used_nxt;

  // Press times are only ever read for the long-press buttons.
  logic [31:0] hold_times_r [8];
  logic        ht_we;
  logic [31:0] ht_wdata;

  logic        last_valid_r, last_valid_nxt;
  logic [6:0]  last_btn_r, last_btn_nxt;
  logic [31:0] last_time_r, last_time_nxt;

  logic        c_press_v_r, c_press_v_nxt;
  result_t     c_press_r, c_press_nxt;
  logic        c_pr_v_r, c_pr_v_nxt;
  result_t     c_pr_r, c_pr_nxt;

  logic [2:0]  idx_r, idx_nxt;
  logic        pend_v_r, pend_v_nxt;
  result_t     pend_r, pend_nxt;

  logic        out_valid_r, out_valid_nxt;
  result_t     out_r, out_nxt;
  logic        out_last_r, out_last_nxt;

  // Shared time unit: one wrapping subtract and one magnitude compare.
  logic [31:0] sub_b;
  logic [16:0] thr;
  logic [31:0] diff;
  logic        diff_lt;

  logic        in_accept;
  logic        out_free;
  logic        pressed;
  logic        in_hold;
  logic        dc;
  logic        dflag;
  logic        pr_ok;
  match_t      pm, prm;
  logic [6:0]  scan_btn;
  logic [31:0] scan_time;
  logic        fire;
  result_t     hold_res;

  assign in_tready = (state_r == ST_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_tready;

  assign scan_btn  = HOLD_LO + {4'b0, idx_r};
  assign scan_time = hold_times_r[idx_r];

  always_comb begin
    if (state_r == ST_NOTE) begin
      sub_b = last_time_r;
      thr   = {1'b0, dclick_r};
    end else begin
      // held > hold_ms is the same as not (held < hold_ms + 1)
      sub_b = scan_time;
      thr   = {1'b0, hold_r} + 17'd1;
    end
    diff    = now_r - sub_b;
    diff_lt = diff < {15'b0, thr};
  end

  assign pressed = (vel_r >= VEL_PRESS);
  assign in_hold = (btn_r >= HOLD_LO) && (btn_r <= HOLD_HI);
  assign pm      = find_press(btn_r);
  assign prm     = find_pr(btn_r);
  assign dc      = pressed && last_valid_r && (last_btn_r == btn_r) && diff_lt;
  assign dflag   = double_r[btn_r] || dc;
  // In this table a hold-used button only suppresses its release; a press clears the mark.
  assign pr_ok   = prm.hit && (pressed || !hold_used_r[btn_r]);

  assign fire = pressed_r[scan_btn] && !hold_used_r[scan_btn] &&
                (scan_time != 32'd0) && !diff_lt;

  always_comb begin
    hold_res                = '0;
    hold_res.button         = scan_btn;
    hold_res.handler_table  = TAB_HOLD;
    hold_res.is_press       = 1'b1;
    hold_res.hold_index     = {1'b0, idx_r} + 4'd1;
  end

  always_comb begin
    state_nxt      = state_r;
    btn_nxt        = btn_r;
    vel_nxt        = vel_r;
    now_nxt        = now_r;
    pressed_nxt    = pressed_r;
    double_nxt     = double_r;
    hold_used_nxt  = hold_used_r;
    last_valid_nxt = last_valid_r;
    last_btn_nxt   = last_btn_r;
    last_time_nxt  = last_time_r;
    c_press_v_nxt  = c_press_v_r;
    c_press_nxt    = c_press_r;
    c_pr_v_nxt     = c_pr_v_r;
    c_pr_nxt       = c_pr_r;
    idx_nxt        = idx_r;
    pend_v_nxt     = pend_v_r;
    pend_nxt       = pend_r;
    out_nxt        = out_r;
    out_last_nxt   = out_last_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    ht_we          = 1'b0;
    ht_wdata       = pressed ? now_r : 32'd0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          btn_nxt = in_tdata[14:8];
          vel_nxt = in_tdata[21:15];
          now_nxt = in_tdata[53:22];
          if (in_tuser) begin
            idx_nxt    = 3'd0;
            pend_v_nxt = 1'b0;
            state_nxt  = ST_SCAN;
          end else if ((in_tdata[7:0] & STATUS_MASK) == STATUS_NOTE) begin
            state_nxt = ST_NOTE;
          end
        end
      end

      ST_NOTE: begin
        pressed_nxt[btn_r] = pressed;
        ht_we              = in_hold;
        if (pressed) begin
          hold_used_nxt[btn_r] = 1'b0;
          last_valid_nxt       = 1'b1;
          last_btn_nxt         = btn_r;
          last_time_nxt        = now_r;
        end
        double_nxt[btn_r] = pr_ok ? (dflag && pressed) : dflag;

        c_press_nxt                = '0;
        c_press_nxt.button         = btn_r;
        c_press_nxt.handler_table  = TAB_PRESS;
        c_press_nxt.handler_entry  = pm.entry;
        c_press_nxt.double_variant = dc && pm.has_double;
        c_press_nxt.is_press       = 1'b1;
        c_press_nxt.velocity_out   = vel_r;
        c_press_v_nxt = pressed && pm.hit && ((dc && pm.has_double) || pm.has_single);

        c_pr_nxt                = '0;
        c_pr_nxt.button         = btn_r;
        c_pr_nxt.handler_table  = TAB_PR;
        c_pr_nxt.handler_entry  = prm.entry;
        c_pr_nxt.double_variant = dflag;
        c_pr_nxt.is_press       = pressed;
        c_pr_nxt.velocity_out   = vel_r;
        c_pr_v_nxt = pr_ok && (dflag ? prm.has_double : prm.has_single);

        state_nxt = (c_press_v_nxt || c_pr_v_nxt) ? ST_EMIT : ST_IDLE;
      end

      ST_EMIT: begin
        if (out_free) begin
          if (c_press_v_r) begin
            out_valid_nxt = 1'b1;
            out_nxt       = c_press_r;
            out_last_nxt  = !c_pr_v_r;
            c_press_v_nxt = 1'b0;
            if (!c_pr_v_r) begin
              state_nxt = ST_IDLE;
            end
          end else begin
            out_valid_nxt = 1'b1;
            out_nxt       = c_pr_r;
            out_last_nxt  = 1'b1;
            c_pr_v_nxt    = 1'b0;
            state_nxt     = ST_IDLE;
          end
        end
      end

      ST_SCAN: begin
        // A firing button pushes the word held before it, so the final word
        // of the tick is known when the scan ends.
        if (!(fire && pend_v_r && !out_free)) begin
          if (fire) begin
            hold_used_nxt[scan_btn] = 1'b1;
            if (pend_v_r) begin
              out_valid_nxt = 1'b1;
              out_nxt       = pend_r;
              out_last_nxt  = 1'b0;
            end
            pend_nxt   = hold_res;
            pend_v_nxt = 1'b1;
          end
          if (idx_r == 3'd7) begin
            state_nxt = ST_FLUSH;
          end else begin
            idx_nxt = idx_r + 3'd1;
          end
        end
      end

      ST_FLUSH: begin
        if (!pend_v_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt       = pend_r;
          out_last_nxt  = 1'b1;
          pend_v_nxt    = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      dclick_r     <= DCLICK_RESET;
      hold_r       <= HOLD_RESET;
      pressed_r    <= '0;
      double_r     <= '0;
      hold_used_r  <= '0;
      last_valid_r <= 1'b0;
      last_time_r  <= 32'd0;
      c_press_v_r  <= 1'b0;
      c_pr_v_r     <= 1'b0;
      pend_v_r     <= 1'b0;
      idx_r        <= 3'd0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pressed_r    <= pressed_nxt;
      double_r     <= double_nxt;
      hold_used_r  <= hold_used_nxt;
      last_valid_r <= last_valid_nxt;
      last_time_r  <= last_time_nxt;
      c_press_v_r  <= c_press_v_nxt;
      c_pr_v_r     <= c_pr_v_nxt;
      pend_v_r     <= pend_v_nxt;
      idx_r        <= idx_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_DCLICK: dclick_r <= cfg_data;
          CFG_HOLD:   hold_r   <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers and the press-time store carry no reset; a press-time
  // entry is only read while its pressed flag is set, which implies a write.
  always_ff @(posedge clk) begin
    btn_r        <= btn_nxt;
    vel_r        <= vel_nxt;
    now_r        <= now_nxt;
    last_btn_r   <= last_btn_nxt;
    c_press_r    <= c_press_nxt;
    c_pr_r       <= c_pr_nxt;
    pend_r       <= pend_nxt;
    out_r        <= out_nxt;
    out_last_r   <= out_last_nxt;
    if (ht_we) begin
      hold_times_r[btn_r[2:0]] <= ht_wdata;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_r.handler_table;
  assign out_tdata  = {7'b0, out_r.hold_index, out_r.velocity_out, out_r.is_press,
                       out_r.double_variant, out_r.handler_entry, out_r.button};

  `BGD_ASSERT_IMP(a_idle_no_pending, clk, rst_n, in_tready, !c_press_v_r && !c_pr_v_r && !pend_v_r)
  `BGD_ASSERT_IMP(a_hold_has_index, clk, rst_n, out_valid_r && out_r.handler_table == TAB_HOLD, out_r.hold_index != 4'd0)
  `BGD_ASSERT_IMP(a_note_no_index, clk, rst_n, out_valid_r && out_r.handler_table != TAB_HOLD, out_r.hold_index == 4'd0)
  `BGD_ASSERT_NXT(a_tick_scans, clk, rst_n, in_accept && in_tuser, state_r == ST_SCAN && idx_r == 3'd0)

endmodule

`default_nettype wire

// ===== test/button_gesture_dispatcher_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Button gesture dispatcher testbench
// Streams note events and frame ticks into the dispatcher under random valid
// and ready gaps, predicts every gesture word with an independent model of
// the click, double click and long press rules, and compares each output
// word in order. Register settings change between phases while the block
// is idle.
// ============================================================================

module button_gesture_dispatcher_tb;
  import bgd_pkg::*;

  localparam logic [3:0] NOTE_ON        = 4'h9;
  localparam logic [6:0] PRESS_VELOCITY = 7'd64;
  localparam logic [6:0] HOLD_FIRST     = 7'h18;
  localparam logic [6:0] HOLD_LAST      = 7'h1f;
  localparam logic [1:0] CFG_SPARE2     = 2'd2;
  localparam logic [1:0] CFG_SPARE3     = 2'd3;
  localparam int         SETTLE_CYCLES  = 30;

  typedef struct packed {
    logic        tick;
    logic [7:0]  status;
    logic [6:0]  button;
    logic [6:0]  velocity;
    logic [31:0] stamp;
  } surface_event_t;

  typedef struct packed {
    logic [6:0] button;
    logic [1:0] tab_code;
    logic [4:0] entry;
    logic       dbl;
    logic       press;
    logic [6:0] velocity;
    logic [3:0] hold_idx;
    logic       last;
  } gesture_t;

  typedef struct packed {
    logic [6:0] lo;
    logic [6:0] hi;
    logic       single;
    logic       dbl;
  } span_t;

  // Button ranges that fire on the down edge only.
  localparam span_t DOWN_SPANS [17] = '{
    '{7'h08, 7'h0f, 1'b0, 1'b1}, '{7'h18, 7'h1f, 1'b0, 1'b1},
    '{7'h35, 7'h35, 1'b1, 1'b0}, '{7'h36, 7'h3d, 1'b1, 1'b0},
    '{7'h3e, 7'h45, 1'b1, 1'b0}, '{7'h4a, 7'h4e, 1'b1, 1'b0},
    '{7'h50, 7'h50, 1'b1, 1'b0}, '{7'h51, 7'h51, 1'b1, 1'b0},
    '{7'h52, 7'h52, 1'b1, 1'b0}, '{7'h56, 7'h56, 1'b1, 1'b0},
    '{7'h57, 7'h57, 1'b1, 1'b0}, '{7'h59, 7'h59, 1'b1, 1'b0},
    '{7'h5a, 7'h5a, 1'b1, 1'b0}, '{7'h5b, 7'h5f, 1'b0, 1'b1},
    '{7'h64, 7'h64, 1'b1, 1'b0}, '{7'h65, 7'h65, 1'b1, 1'b0},
    '{7'h71, 7'h71, 1'b1, 1'b0}
  };

  // Button ranges that fire on both edges.
  localparam span_t EDGE_SPANS [16] = '{
    '{7'h00, 7'h07, 1'b1, 1'b1}, '{7'h08, 7'h0f, 1'b1, 1'b0},
    '{7'h10, 7'h17, 1'b1, 1'b0}, '{7'h18, 7'h1f, 1'b1, 1'b0},
    '{7'h20, 7'h27, 1'b1, 1'b0}, '{7'h28, 7'h2d, 1'b1, 1'b0},
    '{7'h2e, 7'h31, 1'b1, 1'b0}, '{7'h32, 7'h32, 1'b1, 1'b0},
    '{7'h33, 7'h33, 1'b1, 1'b0}, '{7'h34, 7'h34, 1'b1, 1'b1},
    '{7'h46, 7'h49, 1'b1, 1'b0}, '{7'h54, 7'h54, 1'b1, 1'b0},
    '{7'h55, 7'h55, 1'b1, 1'b0}, '{7'h5b, 7'h5f, 1'b1, 1'b0},
    '{7'h60, 7'h63, 1'b1, 1'b0}, '{7'h68, 7'h70, 1'b1, 1'b0}
  };

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata   = '0;
  logic        in_tuser   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index  = '0;
  logic [15:0] cfg_data   = '0;

  // Model state.
  logic        down_mark   [128];
  logic        double_mark [128];
  logic        hold_used   [128];
  logic [31:0] down_time   [128];
  logic [6:0]  recent_button;
  logic        recent_valid;
  logic [31:0] recent_time;
  logic [15:0] dclick_window;
  logic [15:0] hold_limit;

  surface_event_t surface_events [$];
  gesture_t       expected_gestures [$];
  surface_event_t offered;

  int unsigned queued_events   = 0;
  int unsigned live_events     = 0;
  int unsigned accepted_events = 0;
  int unsigned mismatches      = 0;
  int unsigned in_idle_rate    = 0;
  int unsigned out_idle_rate   = 0;
  int unsigned in_gap          = 0;
  int unsigned out_gap         = 0;
  logic        out_holdoff     = 1'b0;
  logic [31:0] surface_ms      = 32'd0;
  int          phase;

  button_gesture_dispatcher i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic void clear_gesture_state();
    for (int i = 0; i < 128; i++) begin
      down_mark[i]   = 1'b0;
      double_mark[i] = 1'b0;
      hold_used[i]   = 1'b0;
      down_time[i]   = 32'd0;
    end
    recent_button = 7'd0;
    recent_valid  = 1'b0;
    recent_time   = 32'd0;
    dclick_window = 16'd250;
    hold_limit    = 16'd333;
  endfunction

  // Works out the gesture words one accepted event causes, in output order.
  function automatic void predict_gestures(input surface_event_t ev);
    gesture_t   fresh [$];
    logic       down;
    logic       dclick;
    logic [6:0] b;
    logic [6:0] hb;
    b = ev.button;
    if (ev.tick) begin
      for (int k = 0; k < 8; k++) begin
        hb = HOLD_FIRST + 7'(k);
        if (down_mark[hb] && !hold_used[hb] && down_time[hb] != 32'd0 &&
            (ev.stamp - down_time[hb]) > {16'd0, hold_limit}) begin
          hold_used[hb] = 1'b1;
          fresh.push_back('{hb, TAB_HOLD, 5'd0, 1'b0, 1'b1, 7'd0, 4'(k + 1), 1'b0});
        end
      end
    end else if (ev.status[7:4] == NOTE_ON) begin
      down = ev.velocity >= PRESS_VELOCITY;
      down_mark[b] = down;
      down_time[b] = down ? ev.stamp : 32'd0;
      if (down) begin
        hold_used[b] = 1'b0;
        dclick = recent_valid && recent_button == b &&
                 (ev.stamp - recent_time) < {16'd0, dclick_window};
        recent_valid  = 1'b1;
        recent_button = b;
        recent_time   = ev.stamp;
        if (dclick) double_mark[b] = 1'b1;
        for (int i = 0; i < 17; i++) begin
          if (DOWN_SPANS[i].lo <= b && b <= DOWN_SPANS[i].hi) begin
            if (dclick && DOWN_SPANS[i].dbl)
              fresh.push_back('{b, TAB_PRESS, 5'(i), 1'b1, 1'b1, ev.velocity, 4'd0, 1'b0});
            if (DOWN_SPANS[i].single)
              fresh.push_back('{b, TAB_PRESS, 5'(i), 1'b0, 1'b1, ev.velocity, 4'd0, 1'b0});
          end
        end
      end
      // A release after a long press offers nothing and keeps the double mark.
      for (int i = 0; i < 16; i++) begin
        if (EDGE_SPANS[i].lo <= b && b <= EDGE_SPANS[i].hi && (!hold_used[b] || down)) begin
          if (double_mark[b]) begin
            double_mark[b] = down;
            if (EDGE_SPANS[i].dbl)
              fresh.push_back('{b, TAB_PR, 5'(i), 1'b1, down, ev.velocity, 4'd0, 1'b0});
          end else if (EDGE_SPANS[i].single) begin
            fresh.push_back('{b, TAB_PR, 5'(i), 1'b0, down, ev.velocity, 4'd0, 1'b0});
          end
        end
      end
    end
    if (fresh.size() > 0) fresh[fresh.size() - 1].last = 1'b1;
    foreach (fresh[i]) expected_gestures.push_back(fresh[i]);
  endfunction

  function automatic void check_gesture();
    gesture_t seen;
    gesture_t want;
    seen = '{out_tdata[6:0], out_tuser, out_tdata[11:7], out_tdata[12], out_tdata[13],
             out_tdata[20:14], out_tdata[24:21], out_tlast};
    if (expected_gestures.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected gesture word %p", seen);
      return;
    end
    want = expected_gestures.pop_front();
    if (seen.button != want.button || seen.tab_code != want.tab_code ||
        seen.entry != want.entry || seen.dbl != want.dbl || seen.press != want.press ||
        seen.velocity != want.velocity || seen.hold_idx != want.hold_idx ||
        seen.last != want.last) begin
      mismatches++;
      if (mismatches <= 10) $display("gesture mismatch: expected %p, got %p", want, seen);
    end
  endfunction

  // Input driver: offers queued events, with random bursts of idle cycles.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        predict_gestures(offered);
        accepted_events++;
      end
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (surface_events.size() > 0 && in_idle_rate != 0 &&
                     $urandom_range(0, 15) < in_idle_rate) begin
          in_gap = $urandom_range(0, 16);
          in_tvalid <= 1'b0;
        end else if (surface_events.size() > 0) begin
          offered = surface_events.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= offered.tick;
          in_tdata  <= {2'b00, offered.stamp, offered.velocity, offered.button, offered.status};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: checks each word taken and stalls at random.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) check_gesture();
      if (out_holdoff) begin
        out_tready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else if (out_idle_rate != 0 && $urandom_range(0, 15) < out_idle_rate) begin
        out_gap = $urandom_range(0, 16);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // One long receiver stall while events keep coming, so the block backs up.
  initial begin
    wait (accepted_events >= 130);
    @(negedge clk);
    out_holdoff = 1'b1;
    repeat (300) @(negedge clk);
    out_holdoff = 1'b0;
  end

  function automatic void queue_event(input surface_event_t ev);
    surface_events.push_back(ev);
    queued_events++;
    if (ev.tick || ev.status[7:4] == NOTE_ON) live_events++;
  endfunction

  function automatic void put_note(input logic [7:0] st, input logic [6:0] b,
                                   input logic [6:0] vel, input logic [31:0] t);
    queue_event('{1'b0, st, b, vel, t});
  endfunction

  // A frame tick carries random junk in the fields it does not use.
  function automatic void put_tick(input logic [31:0] t);
    queue_event('{1'b1, 8'($urandom), 7'($urandom), 7'($urandom), t});
  endfunction

  function automatic logic [7:0] note_on_status();
    return {NOTE_ON, 4'($urandom)};
  endfunction

  function automatic logic [6:0] press_velocity();
    return 7'($urandom_range(64, 127));
  endfunction

  function automatic logic [6:0] release_velocity();
    return 7'($urandom_range(0, 63));
  endfunction

  function automatic logic [6:0] pick_button();
    case ($urandom_range(0, 9))
      0, 1, 2: return 7'($urandom_range(0, 7));
      3:       return 7'h34;
      4:       return 7'($urandom_range(8'h5b, 8'h5f));
      5, 6:    return 7'($urandom_range(8'h08, 8'h1f));
      default: return 7'($urandom_range(0, 127));
    endcase
  endfunction

  function automatic void queue_directed();
    put_note(8'h80, 7'h00, 7'd127, 32'd1000);        // wrong status, ignored
    put_note(8'h9f, 7'h00, 7'd127, 32'd1000);
    put_note(8'h90, 7'h00, 7'd64, 32'd1249);         // double click just inside
    put_note(8'h90, 7'h00, 7'd63, 32'd1300);         // double release
    put_note(8'h90, 7'h00, 7'd64, 32'd1549);         // too late for a double
    put_note(8'h90, 7'h00, 7'd0, 32'd1600);
    put_note(8'h90, 7'h18, 7'd127, 32'd2000);
    queue_event('{1'b1, 8'hff, 7'h7f, 7'h7f, 32'd2333}); // held exactly the limit
    put_tick(32'd2334);                              // long press fires
    put_note(8'h90, 7'h18, 7'd0, 32'd2400);          // release swallowed
    put_note(8'h90, 7'h1f, 7'd100, 32'd0);           // pressed at time zero
    put_tick(32'hffff_ffff);
    put_note(8'h90, 7'h1f, 7'd100, 32'd5000);
    put_tick(32'd4000);                              // wrapped held time fires
    put_note(8'h9a, 7'h1f, 7'd0, 32'd5001);
    put_note(8'h90, 7'h5b, 7'd127, 32'd6000);
    put_note(8'h90, 7'h5b, 7'd127, 32'd6100);
    put_note(8'h90, 7'h5b, 7'd10, 32'd6200);
    put_note(8'h90, 7'h34, 7'd127, 32'd7000);
    put_note(8'h90, 7'h34, 7'd127, 32'd7001);
    put_note(8'h90, 7'h7f, 7'd127, 32'd8000);        // no table covers it
    put_note(8'h90, 7'h71, 7'd127, 32'd8001);
    put_note(8'h90, 7'h0f, 7'd127, 32'd8002);
    put_note(8'h90, 7'h0f, 7'd127, 32'd8003);
    put_note(8'h90, 7'h65, 7'd127, 32'd8004);
  endfunction

  // Mostly well-formed gestures with random timing around the current limits.
  function automatic void random_phase(input int unsigned quota);
    int unsigned goal;
    int unsigned kind;
    int unsigned window;
    int unsigned hold;
    int unsigned d;
    logic [31:0] t0;
    logic [7:0]  mask;
    logic [7:0]  st;
    logic [6:0]  b;
    goal   = live_events + quota;
    window = 32'(dclick_window);
    hold   = 32'(hold_limit);
    while (live_events < goal) begin
      kind = $urandom_range(0, 99);
      if (kind < 25) begin
        b = pick_button();
        surface_ms += $urandom_range(0, 400);
        put_note(note_on_status(), b, press_velocity(), surface_ms);
        if (b >= HOLD_FIRST && b <= HOLD_LAST && $urandom_range(0, 1) == 1) begin
          surface_ms += $urandom_range(0, hold + 2);
          put_tick(surface_ms);
        end
        surface_ms += $urandom_range(0, hold + 50);
        put_note(note_on_status(), b, release_velocity(), surface_ms);
      end else if (kind < 45) begin
        b = pick_button();
        surface_ms += $urandom_range(1, 300);
        t0 = surface_ms;
        put_note(note_on_status(), b, press_velocity(), surface_ms);
        for (int n = $urandom_range(1, 2); n > 0; n--) begin
          if ($urandom_range(0, 3) == 0) d = window - 1 + $urandom_range(0, 1);
          else d = $urandom_range(0, window + window / 2 + 1);
          surface_ms = t0 + 32'($urandom_range(0, d));
          put_note(note_on_status(), b, release_velocity(), surface_ms);
          surface_ms = t0 + d;
          t0 = surface_ms;
          put_note(note_on_status(), b, press_velocity(), surface_ms);
        end
        surface_ms += $urandom_range(0, 100);
        put_note(note_on_status(), b, release_velocity(), surface_ms);
      end else if (kind < 62) begin
        b = HOLD_FIRST + 7'($urandom_range(0, 7));
        surface_ms += $urandom_range(1, 300);
        t0 = surface_ms;
        put_note(note_on_status(), b, press_velocity(), surface_ms);
        for (int n = $urandom_range(1, 3); n > 0; n--) begin
          if ($urandom_range(0, 1) == 0) d = hold + $urandom_range(0, 1);
          else d = $urandom_range(0, 2 * hold + 2);
          surface_ms = t0 + d;
          put_tick(surface_ms);
        end
        surface_ms += $urandom_range(0, 50);
        put_note(note_on_status(), b, release_velocity(), surface_ms);
      end else if (kind < 70) begin
        // Several hold-range buttons at once; an all-down chord gives eight words.
        mask = ($urandom_range(0, 2) == 0) ? 8'hff : 8'($urandom) | 8'h01;
        for (int k = 0; k < 8; k++) begin
          if (mask[k]) begin
            surface_ms += $urandom_range(1, 20);
            put_note(note_on_status(), HOLD_FIRST + 7'(k), press_velocity(), surface_ms);
          end
        end
        surface_ms += hold + $urandom_range(1, 60);
        put_tick(surface_ms);
        if ($urandom_range(0, 1) == 1) begin
          surface_ms += $urandom_range(0, 40);
          put_tick(surface_ms);
        end
        for (int k = 0; k < 8; k++) begin
          if (mask[k] && $urandom_range(0, 4) != 0) begin
            surface_ms += $urandom_range(0, 20);
            put_note(note_on_status(), HOLD_FIRST + 7'(k), release_velocity(), surface_ms);
          end
        end
      end else if (kind < 84) begin
        surface_ms += $urandom_range(0, 2 * hold + 2);
        put_tick(surface_ms);
      end else begin
        case ($urandom_range(0, 3))
          0, 1: begin
            st = 8'($urandom);
            if (st[7:4] == NOTE_ON) st[4] = 1'b0;
            put_note(st, 7'($urandom), 7'($urandom), 32'($urandom));
          end
          2: begin
            surface_ms = $urandom();
            put_note(8'($urandom), 7'($urandom), 7'($urandom), surface_ms);
          end
          default: begin
            surface_ms = $urandom();
            put_tick(surface_ms);
          end
        endcase
      end
    end
  endfunction

  task automatic write_register(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_DCLICK) dclick_window = val;
    else if (idx == CFG_HOLD) hold_limit = val;
  endtask

  // Waits until every queued event was taken and every gesture word arrived,
  // then gives the block time to finish events that produce no word.
  task automatic wait_drained();
    do @(posedge clk);
    while (accepted_events != queued_events || expected_gestures.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    clear_gesture_state();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    in_idle_rate  = 3;
    out_idle_rate = 3;
    queue_directed();
    wait_drained();
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_register(CFG_SPARE2, 16'hffff);
          write_register(CFG_DCLICK, 16'd0);
          write_register(CFG_SPARE3, 16'h0001);
          write_register(CFG_HOLD, 16'd0);
        end
        1: begin
          write_register(CFG_DCLICK, 16'hffff);
          write_register(CFG_HOLD, 16'hffff);
        end
        2: begin
          write_register(CFG_HOLD, 16'd1);
          write_register(CFG_DCLICK, 16'd1);
        end
        3: begin
          write_register(CFG_DCLICK, 16'($urandom));
          write_register(CFG_HOLD, 16'($urandom));
        end
        4: begin
          write_register(CFG_DCLICK, 16'($urandom_range(1, 2000)));
          write_register(CFG_HOLD, 16'($urandom_range(1, 2000)));
        end
        default: begin
          write_register(CFG_DCLICK, 16'd250);
          write_register(CFG_HOLD, 16'd333);
        end
      endcase
      if (phase == 5) begin
        in_idle_rate  = 0;
        out_idle_rate = 0;
      end else begin
        in_idle_rate  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        out_idle_rate = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
      surface_ms = (phase == 3) ? $urandom() : 32'($urandom_range(1, 5000));
      random_phase(74);
      wait_drained();
    end
    if (mismatches == 0 && expected_gestures.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== button_gesture_dispatcher.f =====
+incdir+rtl
rtl/bgd_pkg.sv
rtl/button_gesture_dispatcher.sv
test/button_gesture_dispatcher_tb.sv
